// ===== rtl/dnrs_pkg.sv =====
// Shared constants, types and helper functions for the directional nearest rectangle selector.
package dnrs_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int COORD_BITS  = 12;
    localparam int IDX_BITS    = $clog2(MAX_ENTRIES);
    localparam int SLOT_W      = 5;
    localparam int STEP_W      = 2;

    localparam int CONE_SIDE_MUL = 5;
    localparam int CONE_FWD_MUL  = 2;
    localparam int SIDE_WEIGHT   = 2;

    localparam int CTR_W   = COORD_BITS + 1;
    localparam int DIFF_W  = COORD_BITS + 2;
    localparam int PROD_W  = COORD_BITS + 3;
    localparam int FWD_W   = COORD_BITS + 4;
    localparam int SCORE_W = COORD_BITS + 6;
    localparam int CONE_W  = COORD_BITS + 7;

    localparam int IN_FIELDS_W = SLOT_W + 4 * COORD_BITS + 2 + 2 * STEP_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SLOT_W + 7) / 8) * 8;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic signed [STEP_W-1:0] STEP_PLUS1  = 2'sb01;
    localparam logic signed [STEP_W-1:0] STEP_MINUS1 = 2'sb11;
    localparam logic signed [STEP_W-1:0] STEP_MINUS2 = 2'sb10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } dnrs_state_t;

    typedef struct packed {
        logic signed [STEP_W-1:0]     step_y;
        logic signed [STEP_W-1:0]     step_x;
        logic                         enabled;
        logic                         present;
        logic [COORD_BITS-1:0]        rect_h;
        logic [COORD_BITS-1:0]        rect_w;
        logic [COORD_BITS-1:0]        rect_y;
        logic [COORD_BITS-1:0]        rect_x;
        logic [SLOT_W-1:0]            slot;
    } dnrs_item_t;

    typedef struct packed {
        logic                wr_en;
        logic                start;
        logic                rd_en;
        logic [IDX_BITS-1:0] rd_addr;
        logic                load_out;
    } dnrs_cmd_t;

    typedef struct packed {
        logic busy;
    } dnrs_status_t;

    function automatic logic signed [PROD_W-1:0] mul_step(
        input logic signed [DIFF_W-1:0] v,
        input logic signed [STEP_W-1:0] s
    );
        logic signed [PROD_W-1:0] ve;
        logic signed [PROD_W-1:0] res;
        ve = PROD_W'(v);
        case (s)
            STEP_PLUS1:  res = ve;
            STEP_MINUS1: res = -ve;
            STEP_MINUS2: res = -(ve <<< 1);
            default:     res = '0;
        endcase
        return res;
    endfunction

    function automatic logic [PROD_W-1:0] abs_prod(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] res;
        res = (v < 0) ? -v : v;
        return res;
    endfunction

endpackage

// ===== rtl/dnrs_ctrl.sv =====
// Controller state machine that sequences writes, table scans and result delivery.
module dnrs_ctrl
    import dnrs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         command,
    input  logic         m_tready,
    input  dnrs_status_t status,
    output logic         s_tready,
    output logic         m_tvalid,
    output dnrs_cmd_t    cmd
);

    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(MAX_ENTRIES - 1);

    dnrs_state_t         state_reg, state_next;
    logic [IDX_BITS-1:0] cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic                accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        s_tready     = 1'b0;
        accept       = 1'b0;
        cmd.wr_en    = 1'b0;
        cmd.start    = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.rd_addr  = cnt_reg;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                accept    = s_tvalid;
                cmd.wr_en = accept && (command == CMD_WRITE);
                cmd.start = accept && (command == CMD_QUERY);
                if (cmd.start)
                begin
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

`ifndef ASSERT_OFF
    a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == ST_SCAN) && (cnt_reg == '0))
        else $error("query did not start its scan at entry zero");

    a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && (cnt_reg == LAST_IDX) |=> state_reg == ST_DRAIN)
        else $error("scan did not end after the last entry");

    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> !status.busy)
        else $error("result taken while the scan pipeline still held entries");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("loaded result is not offered");
`endif

endmodule

// ===== rtl/dnrs_datapath.sv =====
// Datapath with the entry table, the scoring pipeline, the best-entry tracker and the result registers.
module dnrs_datapath
    import dnrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dnrs_item_t        item,
    input  dnrs_cmd_t         cmd,
    output dnrs_status_t      status,
    output logic              out_found,
    output logic [SLOT_W-1:0] out_slot
);

    logic [2*CTR_W-1:0]       mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]   use_reg;

    logic [CTR_W-1:0]         wr_cx, wr_cy;
    logic [IDX_BITS-1:0]      wr_addr;
    logic                     wr_ok;
    logic                     wr_use;

    logic [CTR_W-1:0]         src_cx_reg, src_cy_reg;
    logic signed [STEP_W-1:0] dx_reg, dy_reg;
    logic                     src_empty_reg;

    logic                     r_valid_reg, r_use_reg;
    logic [IDX_BITS-1:0]      r_idx_reg;
    logic [2*CTR_W-1:0]       r_data_reg;
    logic [CTR_W-1:0]         r_cx, r_cy;

    logic                     a_valid_reg, a_use_reg;
    logic [IDX_BITS-1:0]      a_idx_reg;
    logic signed [DIFF_W-1:0] a_cx_reg, a_cy_reg;

    logic                     b_valid_reg, b_use_reg;
    logic [IDX_BITS-1:0]      b_idx_reg;
    logic signed [FWD_W-1:0]  b_fwd_reg, b_fwd_next;
    logic [FWD_W-1:0]         b_side_reg, b_side_next;

    logic [FWD_W-1:0]         fwd_u;
    logic                     fwd_pos, cone_ok, qualify, better;
    logic [CONE_W-1:0]        cone_lhs, cone_rhs;
    logic [SCORE_W-1:0]       score;

    logic                     best_have_reg;
    logic [SCORE_W-1:0]       best_cost_reg;
    logic [IDX_BITS-1:0]      best_idx_reg;
    logic                     out_found_reg;
    logic [SLOT_W-1:0]        out_slot_reg;

    assign wr_cx   = CTR_W'(item.rect_x) + CTR_W'(item.rect_w >> 1);
    assign wr_cy   = CTR_W'(item.rect_y) + CTR_W'(item.rect_h >> 1);
    assign wr_addr = IDX_BITS'(item.slot);
    assign wr_ok   = cmd.wr_en && (32'(item.slot) < MAX_ENTRIES);
    assign wr_use  = item.present && item.enabled && (item.rect_w != '0) && (item.rect_h != '0);

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[wr_addr] <= {wr_cx, wr_cy};
        end
        if (cmd.rd_en)
        begin
            r_data_reg <= mem[cmd.rd_addr];
        end
    end

    assign r_cx = r_data_reg[2*CTR_W-1:CTR_W];
    assign r_cy = r_data_reg[CTR_W-1:0];

    always_comb
    begin
        b_fwd_next  = FWD_W'(mul_step(a_cx_reg, dx_reg)) + FWD_W'(mul_step(a_cy_reg, dy_reg));
        b_side_next = FWD_W'(abs_prod(mul_step(a_cx_reg, dy_reg)))
                    + FWD_W'(abs_prod(mul_step(a_cy_reg, dx_reg)));
    end

    always_comb
    begin
        fwd_u    = b_fwd_reg;
        fwd_pos  = b_fwd_reg > 0;
        cone_lhs = CONE_W'(fwd_u) * CONE_W'(CONE_SIDE_MUL);
        cone_rhs = CONE_W'(b_side_reg) * CONE_W'(CONE_FWD_MUL);
        cone_ok  = cone_rhs <= cone_lhs;
        qualify  = b_use_reg && (src_empty_reg || (fwd_pos && cone_ok));
        if (src_empty_reg)
        begin
            score = '0;
        end
        else
        begin
            score = SCORE_W'(fwd_u) + SCORE_W'(b_side_reg) * SCORE_W'(SIDE_WEIGHT);
        end
        better = b_valid_reg && qualify && (!best_have_reg || (score < best_cost_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_reg       <= '0;
            r_valid_reg   <= 1'b0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            best_have_reg <= 1'b0;
        end
        else
        begin
            if (wr_ok)
            begin
                use_reg[wr_addr] <= wr_use;
            end
            r_valid_reg <= cmd.rd_en;
            a_valid_reg <= r_valid_reg;
            b_valid_reg <= a_valid_reg;
            if (cmd.start)
            begin
                best_have_reg <= 1'b0;
            end
            else if (better)
            begin
                best_have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            src_cx_reg    <= wr_cx;
            src_cy_reg    <= wr_cy;
            dx_reg        <= item.step_x;
            dy_reg        <= item.step_y;
            src_empty_reg <= (item.rect_w == '0) || (item.rect_h == '0);
        end
        r_use_reg  <= use_reg[cmd.rd_addr];
        r_idx_reg  <= cmd.rd_addr;
        a_use_reg  <= r_use_reg;
        a_idx_reg  <= r_idx_reg;
        a_cx_reg   <= $signed({1'b0, r_cx}) - $signed({1'b0, src_cx_reg});
        a_cy_reg   <= $signed({1'b0, r_cy}) - $signed({1'b0, src_cy_reg});
        b_use_reg  <= a_use_reg;
        b_idx_reg  <= a_idx_reg;
        b_fwd_reg  <= b_fwd_next;
        b_side_reg <= b_side_next;
        if (better)
        begin
            best_cost_reg <= score;
            best_idx_reg  <= b_idx_reg;
        end
        if (cmd.load_out)
        begin
            out_found_reg <= best_have_reg;
            out_slot_reg  <= best_have_reg ? SLOT_W'(best_idx_reg) : '0;
        end
    end

    assign status.busy = r_valid_reg || a_valid_reg || b_valid_reg;
    assign out_found   = out_found_reg;
    assign out_slot    = out_slot_reg;

endmodule

// ===== rtl/directional_nearest_rect_select.sv =====
// Top level of the directional nearest rectangle selector.
// The slave channel takes one beat per command: s_tuser selects a table write or a query.
// A write stores the centre of one rectangle and a use flag (present, enabled, nonzero size) and
// gives no result. A query names a source rectangle and a step direction; the block
// walks the table one entry per cycle and returns one beat on the master channel with
// the found flag in m_tuser and the chosen slot in m_tdata.
// After a query is accepted, the table scan reads one entry per cycle from the entry memory,
// the three-stage scoring pipeline drains, the drain state sees it empty and the done state
// loads the result register, which raises m_tvalid.
// While a query runs, s_tready is low; it rises again as the result is offered, so a new
// query waits for the last one to end, and writes are taken one per cycle while no query runs.
// The result sits in an output register, so new commands are accepted while it waits.
// When the receiver stalls, the result beat holds, and a following query finishes its scan
// and then waits until the previous beat has been taken.
// Reset clears every table entry to not present and drops m_tvalid; the stored coordinates
// are only used for entries that have been written.
module directional_nearest_rect_select
    import dnrs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // slot, rect_x, rect_y, rect_w, rect_h, present, enabled, step_x, step_y, zero fill
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // command
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // chosen_slot, zero fill
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // found
    output logic                   m_tuser
);

    dnrs_item_t        item;
    dnrs_cmd_t         cmd;
    dnrs_status_t      status;
    logic              out_found;
    logic [SLOT_W-1:0] out_slot;

    assign item = dnrs_item_t'(s_tdata[IN_FIELDS_W-1:0]);

    dnrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .command  (s_tuser),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    dnrs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .status    (status),
        .out_found (out_found),
        .out_slot  (out_slot)
    );

    assign m_tdata = OUT_TDATA_W'(out_slot);
    assign m_tuser = out_found;

endmodule
